// ===== design/cpram_pkg.sv =====
// Shared constants, window codes and index helper for the coprocessor RAM access port.
package cpram_pkg;

	localparam int unsigned RAM_WORDS_DEF = 8192;

	localparam logic [23:0] WIN_MASK    = 24'hfe0000;
	localparam logic [23:0] WIN_POINTER = 24'hd00000;
	localparam logic [23:0] WIN_DATA    = 24'hd20000;
	localparam logic [23:0] WIN_SCRATCH = 24'hd80000;
	localparam logic [23:0] WIN_ZERO    = 24'hdc0000;

	localparam logic [15:0] AUTOINC_BIT = 16'h8000;

	localparam logic OP_READ  = 1'b0;
	localparam logic OP_WRITE = 1'b1;

	localparam logic [2:0] SEL_POINTER = 3'd0;
	localparam logic [2:0] SEL_DATA    = 3'd1;
	localparam logic [2:0] SEL_SCRATCH = 3'd2;
	localparam logic [2:0] SEL_ZERO    = 3'd3;
	localparam logic [2:0] SEL_NONE    = 3'd4;

	// reduce a 16-bit pointer modulo the word count by shifted compare-subtract
	function automatic logic [15:0] wrap_index(input logic [15:0] value,
		input int unsigned words);
		logic [23:0] v;
		logic [23:0] step;
		v = {8'd0, value};
		for (int k = 7; k >= 0; k--) begin
			step = 24'(words) << k;
			if (v >= step)
				v = v - step;
		end
		return v[15:0];
	endfunction

endpackage

// ===== design/cpram_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
module cpram_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 8192
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end

endmodule

// ===== design/coprocessor_ram_access_port_unit.sv =====
// Top level of the coprocessor RAM access port: window decode, pointer, latches, word RAM.
// Usage:
//   Command channel: drive op, address and write_data with start high; the transfer
//   is taken at a rising edge where start is high and busy is low.
//   Result channel: done is high for exactly one cycle with read_data and handled;
//   the receiver cannot stall, the result is consumed at the edge ending that cycle.
// Access sequence:
//   Each access is accepted, then executed: the accept cycle issues the word RAM
//   read at the current pointer, the following cycle executes the access (RAM data,
//   commit, pointer step). busy is high during that execute cycle, so a new access
//   cannot be taken while one executes. The result strobe appears in the cycle
//   after execution, while the next access may already be accepted.
//   The word RAM read port is registered and must return data before the pointer
//   may step.
// Reset:
//   arst_n clears the pointer, latches and scratch register, then busy stays high
//   while the word RAM is swept to zero, one entry per cycle.
module coprocessor_ram_access_port_unit #(
	parameter int unsigned RAM_WORDS = cpram_pkg::RAM_WORDS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        op,
	input  logic [23:0] address,
	input  logic [15:0] write_data,
	output logic        done,
	output logic [15:0] read_data,
	output logic        handled
);

	localparam int unsigned IDX_W = $clog2(RAM_WORDS);

	localparam logic [1:0] ST_CLEAR = 2'd0;
	localparam logic [1:0] ST_IDLE  = 2'd1;
	localparam logic [1:0] ST_EXEC  = 2'd2;

	logic [1:0]       state_q;
	logic [IDX_W-1:0] clr_q;
	logic [15:0]      ptr_q;
	logic [15:0]      latch_lo_q;
	logic [15:0]      latch_hi_q;
	logic [31:0]      scratch_q;

	logic             op_s1;
	logic             high_s1;
	logic [2:0]       sel_s1;
	logic [15:0]      wdata_s1;

	logic             done_q;
	logic [15:0]      rdata_q;
	logic             handled_q;

	logic [2:0]       sel_d;
	logic [15:0]      idx_full;
	logic [IDX_W-1:0] idx;
	logic [31:0]      ram_rdata;
	logic             ram_we;
	logic [IDX_W-1:0] ram_waddr;
	logic [31:0]      ram_wdata;

	logic [15:0]      ptr_d;
	logic [15:0]      latch_lo_d;
	logic [15:0]      latch_hi_d;
	logic [31:0]      scratch_d;
	logic [15:0]      rdata_d;
	logic             handled_d;
	logic             commit;
	logic [15:0]      ptr_step;
	logic             accept;

	assign accept   = start && !busy;
	assign busy     = (state_q != ST_IDLE);
	assign idx_full = cpram_pkg::wrap_index(ptr_q, RAM_WORDS);
	assign idx      = idx_full[IDX_W-1:0];

	always_comb begin
		unique case (address & cpram_pkg::WIN_MASK)
			cpram_pkg::WIN_POINTER: sel_d = cpram_pkg::SEL_POINTER;
			cpram_pkg::WIN_DATA:    sel_d = cpram_pkg::SEL_DATA;
			cpram_pkg::WIN_SCRATCH: sel_d = cpram_pkg::SEL_SCRATCH;
			cpram_pkg::WIN_ZERO:    sel_d = cpram_pkg::SEL_ZERO;
			default:                sel_d = cpram_pkg::SEL_NONE;
		endcase
	end

	assign ptr_step = ((ptr_q & cpram_pkg::AUTOINC_BIT) != 16'd0) ? ptr_q + 16'd1 : ptr_q;

	always_comb begin
		ptr_d      = ptr_q;
		latch_lo_d = latch_lo_q;
		latch_hi_d = latch_hi_q;
		scratch_d  = scratch_q;
		rdata_d    = 16'd0;
		handled_d  = 1'b1;
		commit     = 1'b0;
		unique case (sel_s1)
			cpram_pkg::SEL_POINTER: begin
				if (op_s1 == cpram_pkg::OP_WRITE)
					ptr_d = wdata_s1;
				else
					rdata_d = ptr_q;
			end
			cpram_pkg::SEL_DATA: begin
				if (op_s1 == cpram_pkg::OP_WRITE) begin
					if (high_s1) begin
						latch_hi_d = wdata_s1;
						commit     = 1'b1;
						ptr_d      = ptr_step;
					end else begin
						latch_lo_d = wdata_s1;
					end
				end else if (high_s1) begin
					rdata_d = ram_rdata[31:16];
					ptr_d   = ptr_step;
				end else begin
					rdata_d = ram_rdata[15:0];
				end
			end
			cpram_pkg::SEL_SCRATCH: begin
				if (op_s1 == cpram_pkg::OP_WRITE) begin
					if (high_s1)
						scratch_d[31:16] = wdata_s1;
					else
						scratch_d[15:0] = wdata_s1;
				end else begin
					rdata_d = high_s1 ? scratch_q[31:16] : scratch_q[15:0];
				end
			end
			cpram_pkg::SEL_ZERO: rdata_d = 16'd0;
			default: handled_d = 1'b0;
		endcase
		if (op_s1 == cpram_pkg::OP_WRITE)
			rdata_d = 16'd0;
	end

	always_comb begin
		if (state_q == ST_CLEAR) begin
			ram_we    = 1'b1;
			ram_waddr = clr_q;
			ram_wdata = 32'd0;
		end else begin
			ram_we    = (state_q == ST_EXEC) && commit;
			ram_waddr = idx;
			ram_wdata = {wdata_s1, latch_lo_q};
		end
	end

	cpram_ram #(
		.WIDTH(32),
		.DEPTH(RAM_WORDS)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(idx),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			clr_q      <= '0;
			ptr_q      <= 16'd0;
			latch_lo_q <= 16'd0;
			latch_hi_q <= 16'd0;
			scratch_q  <= 32'd0;
			done_q     <= 1'b0;
		end else begin
			done_q <= (state_q == ST_EXEC);
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == IDX_W'(RAM_WORDS - 1))
						state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (accept)
						state_q <= ST_EXEC;
				end
				ST_EXEC: begin
					ptr_q      <= ptr_d;
					latch_lo_q <= latch_lo_d;
					latch_hi_q <= latch_hi_d;
					scratch_q  <= scratch_d;
					state_q    <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1    <= op;
			high_s1  <= address[1];
			sel_s1   <= sel_d;
			wdata_s1 <= write_data;
		end
		if (state_q == ST_EXEC) begin
			rdata_q   <= rdata_d;
			handled_q <= handled_d;
		end
	end

	assign done      = done_q;
	assign read_data = rdata_q;
	assign handled   = handled_q;

	a_done_after_exec: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q == ST_EXEC))
		else $error("result strobe without an executed access");

	a_accept_to_done: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##2 done)
		else $error("accepted transfer did not produce a result");

	a_no_idle_write: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !ram_we)
		else $error("word RAM written while idle");

	a_unhandled_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !handled) |-> (read_data == 16'd0))
		else $error("unhandled access returned data");

endmodule
